/* rtl/amp_pkg.sv */
// Shared types and constants for the AIFF marker position finder.
`timescale 1ns / 1ps

package amp_pkg;

  // Chunk ID 'MARK', big-endian.
  localparam logic [31:0] MARK_ID = 32'h4D41524B;

  // Header is ID, size and marker count; each entry has a fixed ID and position part.
  localparam logic [3:0] HDR_LAST_IDX   = 4'd9;
  localparam logic [2:0] ENTRY_LAST_IDX = 3'd5;

  // Status codes of a result.
  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_BAD_ID   = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE = 3'd2;
  localparam logic [2:0] ST_NO_MATCH = 3'd3;
  localparam logic [2:0] ST_EARLY    = 3'd4;

  // One result item.
  typedef struct packed {
    logic [31:0] marker_position;
    logic        found;
    logic [2:0]  status;
  } result_t;

endpackage

/* rtl/amp_in_if.sv */
// Byte input channel of the AIFF marker position finder.
`timescale 1ns / 1ps

interface amp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

/* rtl/amp_out_if.sv */
// Result output channel of the AIFF marker position finder.
`timescale 1ns / 1ps

interface amp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] marker_position;
  logic        found;
  logic [2:0]  status;

  modport source (output valid, marker_position, found, status, input ready);
  modport sink (input valid, marker_position, found, status, output ready);
endinterface

/* rtl/aiff_marker_position_finder.sv */
// Top level of the AIFF marker position finder: register port, parser and output buffer.
//
//   Channel     Dir   Handshake            Payload
//   data_ch     in    valid/ready          data_byte[7:0], first_byte, last_byte
//   result_ch   out   valid/ready          marker_position[31:0], found, status[2:0]
//   APB         in    psel/penable/pready  target_marker_id at byte address 0
//
// One byte per cycle while the buffer has room; each transfer updates parser registers.
// A result is registered in the output or skid register before it shows on result_ch.
// The two-entry output buffer keeps data_ch ready until two results wait unread.
// Reset is synchronous; the parser starts at chunk byte 0 and the target ID is 0.
`timescale 1ns / 1ps

module aiff_marker_position_finder (
  input  logic        clk,
  input  logic        rst,
  amp_in_if.sink      data_ch,
  amp_out_if.source   result_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic             [15:0] target_marker_id;
  logic             room;
  logic             push;
  amp_pkg::result_t push_res;
  logic             reg_sel;

  // Configuration register port.
  assign pready  = 1'b1;
  assign reg_sel = (paddr == 3'd0);
  assign prdata  = reg_sel ? {16'd0, target_marker_id} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_marker_id <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      target_marker_id <= pwdata[15:0];
    end
  end

  amp_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .data_ch          (data_ch),
    .room             (room),
    .target_marker_id (target_marker_id),
    .push             (push),
    .push_res         (push_res)
  );

  amp_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_res  (push_res),
    .room      (room),
    .result_ch (result_ch)
  );

endmodule

/* rtl/amp_parser.sv */
// Byte-wise MARK chunk parser: header check, entry walk and result generation.
`timescale 1ns / 1ps

module amp_parser (
  input  logic               clk,
  input  logic               rst,
  amp_in_if.sink             data_ch,
  input  logic               room,
  input  logic [15:0]        target_marker_id,
  output logic               push,
  output amp_pkg::result_t   push_res
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_ENTRY,
    PH_LENGTH,
    PH_SKIP,
    PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  hdr_cnt, hdr_cnt_next;
  logic [31:0] chunk_id, chunk_id_next;
  logic [31:0] chunk_size, chunk_size_next;
  logic [15:0] marker_count, marker_count_next;
  logic [15:0] entry_index, entry_index_next;
  logic [2:0]  entry_cnt, entry_cnt_next;
  logic [15:0] entry_id, entry_id_next;
  logic [31:0] entry_pos, entry_pos_next;
  logic [7:0]  skip_rem, skip_rem_next;

  logic        accept;
  logic        emit;
  logic [2:0]  emit_status;
  logic [7:0]  b;

  assign data_ch.ready = room;
  assign accept        = data_ch.valid & room;
  assign b             = data_ch.data_byte;

  // Next parser state for the byte on the channel; a first byte starts from a clean state.
  always_comb begin
    phase_next        = data_ch.first_byte ? PH_HEADER : phase;
    hdr_cnt_next      = data_ch.first_byte ? '0 : hdr_cnt;
    chunk_id_next     = data_ch.first_byte ? '0 : chunk_id;
    chunk_size_next   = data_ch.first_byte ? '0 : chunk_size;
    marker_count_next = data_ch.first_byte ? '0 : marker_count;
    entry_index_next  = data_ch.first_byte ? '0 : entry_index;
    entry_cnt_next    = data_ch.first_byte ? '0 : entry_cnt;
    entry_id_next     = data_ch.first_byte ? '0 : entry_id;
    entry_pos_next    = data_ch.first_byte ? '0 : entry_pos;
    skip_rem_next     = data_ch.first_byte ? '0 : skip_rem;
    emit              = 1'b0;
    emit_status       = amp_pkg::ST_EARLY;

    case (phase_next)
      PH_HEADER: begin
        if (hdr_cnt_next < 4'd4) begin
          chunk_id_next = {chunk_id_next[23:0], b};
        end else if (hdr_cnt_next < 4'd8) begin
          chunk_size_next = {chunk_size_next[23:0], b};
        end else begin
          marker_count_next = {marker_count_next[7:0], b};
        end
        if (hdr_cnt_next == 4'd3 && chunk_id_next != amp_pkg::MARK_ID) begin
          emit        = 1'b1;
          emit_status = amp_pkg::ST_BAD_ID;
        end else if (hdr_cnt_next == 4'd7 &&
                     (chunk_size_next == '0 || chunk_size_next[31])) begin
          emit        = 1'b1;
          emit_status = amp_pkg::ST_BAD_SIZE;
        end else if (hdr_cnt_next == amp_pkg::HDR_LAST_IDX) begin
          if (marker_count_next == '0) begin
            emit        = 1'b1;
            emit_status = amp_pkg::ST_NO_MATCH;
          end else begin
            phase_next     = PH_ENTRY;
            entry_cnt_next = '0;
          end
        end
        hdr_cnt_next = hdr_cnt_next + 4'd1;
      end
      PH_ENTRY: begin
        if (entry_cnt_next < 3'd2) begin
          entry_id_next = {entry_id_next[7:0], b};
        end else begin
          entry_pos_next = {entry_pos_next[23:0], b};
        end
        if (entry_cnt_next == amp_pkg::ENTRY_LAST_IDX) begin
          if (entry_id_next == target_marker_id) begin
            emit        = 1'b1;
            emit_status = amp_pkg::ST_FOUND;
          end else begin
            phase_next = PH_LENGTH;
          end
        end
        entry_cnt_next = entry_cnt_next + 3'd1;
      end
      PH_LENGTH: begin
        entry_index_next = entry_index_next + 16'd1;
        if (entry_index_next == marker_count_next) begin
          emit        = 1'b1;
          emit_status = amp_pkg::ST_NO_MATCH;
        end else begin
          // Text plus pad byte: the next entry starts at an even offset.
          skip_rem_next = b | 8'd1;
          phase_next    = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (skip_rem_next != '0) begin
          skip_rem_next = skip_rem_next - 8'd1;
        end
        if (skip_rem_next == '0) begin
          phase_next     = PH_ENTRY;
          entry_cnt_next = '0;
        end
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase

    // A last byte that completes nothing ends the chunk early.
    if (!emit && data_ch.last_byte && phase_next != PH_DONE) begin
      emit        = 1'b1;
      emit_status = amp_pkg::ST_EARLY;
    end
    if (emit) begin
      phase_next = PH_DONE;
    end
  end

  // Result for this byte.
  assign push                     = accept & emit;
  assign push_res.status          = emit_status;
  assign push_res.found           = (emit_status == amp_pkg::ST_FOUND);
  assign push_res.marker_position = (emit_status == amp_pkg::ST_FOUND) ? entry_pos_next : '0;

  // Parser state registers, updated on each transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      hdr_cnt      <= '0;
      chunk_id     <= '0;
      chunk_size   <= '0;
      marker_count <= '0;
      entry_index  <= '0;
      entry_cnt    <= '0;
      entry_id     <= '0;
      entry_pos    <= '0;
      skip_rem     <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      hdr_cnt      <= hdr_cnt_next;
      chunk_id     <= chunk_id_next;
      chunk_size   <= chunk_size_next;
      marker_count <= marker_count_next;
      entry_index  <= entry_index_next;
      entry_cnt    <= entry_cnt_next;
      entry_id     <= entry_id_next;
      entry_pos    <= entry_pos_next;
      skip_rem     <= skip_rem_next;
    end
  end

  // Once done, only a first byte can produce another result.
  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE && !data_ch.first_byte) |-> !push)
    else $error("result pushed after chunk was already finished");

  // A pushed result leaves the parser finished.
  a_push_done: assert property (@(posedge clk) disable iff (rst)
    push |=> phase == PH_DONE)
    else $error("parser not finished after a result");

endmodule

/* rtl/amp_skid.sv */
// Output register with a skid stage for the result channel.
`timescale 1ns / 1ps

module amp_skid (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  amp_pkg::result_t   push_res,
  output logic               room,
  amp_out_if.source          result_ch
);

  amp_pkg::result_t out_reg;
  amp_pkg::result_t skid_reg;
  logic             out_valid;
  logic             skid_valid;
  logic             pop;

  assign pop  = out_valid & result_ch.ready;
  assign room = ~skid_valid;

  assign result_ch.valid           = out_valid;
  assign result_ch.marker_position = out_reg.marker_position;
  assign result_ch.found           = out_reg.found;
  assign result_ch.status          = out_reg.status;

  // Valid flags: the skid stage fills only when the output register is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || pop) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_reg <= skid_reg;
      end
    end else if (!out_valid || pop) begin
      if (push) begin
        out_reg <= push_res;
      end
    end else if (push) begin
      skid_reg <= push_res;
    end
  end

  // The skid stage never holds a result while the output register is empty.
  a_skid_behind: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage full with output register empty");

  // No result arrives while there is no room for it.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("result pushed into a full buffer");

endmodule

/* bench/amp_checker.sv */
// Checker for the AIFF marker position finder: predicts each chunk's outcome and compares.
`timescale 1ns / 1ps

module amp_checker (
  input  logic        clk,
  input  logic        rst,
  amp_in_if           data_mon,
  amp_out_if          result_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          error_count,
  output int          outstanding
);

  typedef enum logic [2:0] {
    HEADER,
    ENTRY_FIXED,
    NAME_LENGTH,
    NAME_SKIP,
    CLOSED
  } parse_phase_t;

  // Shadow copy of the parser and its target register.
  parse_phase_t phase;
  logic [3:0]   hdr_count;
  logic [31:0]  id_word;
  logic [31:0]  size_word;
  logic [15:0]  marker_total;
  logic [15:0]  entry_seen;
  logic [2:0]   entry_count;
  logic [15:0]  entry_id;
  logic [31:0]  entry_pos;
  logic [8:0]   skip_left;
  logic [15:0]  match_id;

  // Outcomes predicted for chunks whose result has not been read yet.
  amp_pkg::result_t chunk_outcomes[$];

  function automatic void clear_parser();
    phase        = HEADER;
    hdr_count    = '0;
    id_word      = '0;
    size_word    = '0;
    marker_total = '0;
    entry_seen   = '0;
    entry_count  = '0;
    entry_id     = '0;
    entry_pos    = '0;
    skip_left    = '0;
  endfunction

  function automatic void close_chunk(input logic [2:0] status, input logic [31:0] pos);
    amp_pkg::result_t r;
    r.marker_position = (status == amp_pkg::ST_FOUND) ? pos : 32'd0;
    r.found           = (status == amp_pkg::ST_FOUND);
    r.status          = status;
    chunk_outcomes.push_back(r);
    phase = CLOSED;
  endfunction

  // Advances the parser by one chunk byte; a byte that closes the chunk suppresses the
  // early-end status.
  function automatic void parse_chunk_byte(input logic [7:0] b, input logic first,
                                           input logic last);
    logic [3:0] hn;
    logic [2:0] en;
    logic       closed;
    closed = 1'b0;
    if (first) clear_parser();
    case (phase)
      HEADER: begin
        hn = hdr_count;
        if (hn < 4) id_word = {id_word[23:0], b};
        else if (hn < 8) size_word = {size_word[23:0], b};
        else marker_total = {marker_total[7:0], b};
        hdr_count = hn + 4'd1;
        if (hn == 4'd3 && id_word != amp_pkg::MARK_ID) begin
          close_chunk(amp_pkg::ST_BAD_ID, 32'd0);
          closed = 1'b1;
        end else if (hn == 4'd7 && (size_word == 32'd0 || size_word[31])) begin
          close_chunk(amp_pkg::ST_BAD_SIZE, 32'd0);
          closed = 1'b1;
        end else if (hn == amp_pkg::HDR_LAST_IDX) begin
          if (marker_total == 16'd0) begin
            close_chunk(amp_pkg::ST_NO_MATCH, 32'd0);
            closed = 1'b1;
          end else begin
            phase       = ENTRY_FIXED;
            entry_count = '0;
          end
        end
      end
      ENTRY_FIXED: begin
        en = entry_count;
        if (en < 2) entry_id = {entry_id[7:0], b};
        else entry_pos = {entry_pos[23:0], b};
        entry_count = en + 3'd1;
        if (en == amp_pkg::ENTRY_LAST_IDX) begin
          if (entry_id == match_id) begin
            close_chunk(amp_pkg::ST_FOUND, entry_pos);
            closed = 1'b1;
          end else begin
            phase = NAME_LENGTH;
          end
        end
      end
      NAME_LENGTH: begin
        entry_seen = entry_seen + 16'd1;
        if (entry_seen == marker_total) begin
          close_chunk(amp_pkg::ST_NO_MATCH, 32'd0);
          closed = 1'b1;
        end else begin
          // Fixed part plus length byte is odd, so an even-length name carries a pad byte.
          skip_left = {1'b0, b} + {8'd0, ~b[0]};
          phase     = NAME_SKIP;
        end
      end
      NAME_SKIP: begin
        if (skip_left != 9'd0) skip_left = skip_left - 9'd1;
        if (skip_left == 9'd0) begin
          phase       = ENTRY_FIXED;
          entry_count = '0;
        end
      end
      default: begin
        // Bytes after the result are ignored until the next chunk start.
        closed = 1'b1;
      end
    endcase
    if (!closed && last) close_chunk(amp_pkg::ST_EARLY, 32'd0);
  endfunction

  // Sample every channel at the rising edge.
  always @(posedge clk) begin : watch
    amp_pkg::result_t want;
    if (rst) begin
      clear_parser();
      match_id = '0;
      chunk_outcomes.delete();
      error_count = 0;
    end else begin
      // Register writes and read-back.
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == 3'd0) match_id = pwdata[15:0];
        end else if (paddr == 3'd0 && prdata !== {16'd0, match_id}) begin
          $display("%0t: target read-back expected %h, got %h", $time, {16'd0, match_id},
                   prdata);
          error_count++;
        end
      end

      if (data_mon.valid && data_mon.ready)
        parse_chunk_byte(data_mon.data_byte, data_mon.first_byte, data_mon.last_byte);

      if (result_mon.valid && result_mon.ready) begin
        if (chunk_outcomes.size() == 0) begin
          $display("%0t: unexpected result, expected none, got position %h found %b status %0d",
                   $time, result_mon.marker_position, result_mon.found, result_mon.status);
          error_count++;
        end else begin
          want = chunk_outcomes.pop_front();
          if (result_mon.marker_position !== want.marker_position) begin
            $display("%0t: marker_position expected %h, got %h", $time, want.marker_position,
                     result_mon.marker_position);
            error_count++;
          end
          if (result_mon.found !== want.found) begin
            $display("%0t: found expected %b, got %b", $time, want.found, result_mon.found);
            error_count++;
          end
          if (result_mon.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status,
                     result_mon.status);
            error_count++;
          end
        end
      end
    end
    outstanding = chunk_outcomes.size();
  end

endmodule

/* bench/tb_top.sv */
// Testbench top for the AIFF marker position finder: clock, reset, chunk stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } stream_byte_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          error_count;
  int          outstanding;
  int          src_idle_pct = 0;
  int          sink_idle_pct = 0;
  int          sent = 0;
  logic        byte_taken = 1'b0;
  logic        apb_done = 1'b0;
  logic [15:0] search_id = '0;

  // Bytes of the chunk being assembled.
  stream_byte_t chunk_q[$];

  amp_in_if  data_if ();
  amp_out_if result_if ();

  aiff_marker_position_finder DUT (
    .clk       (clk),
    .rst       (rst),
    .data_ch   (data_if),
    .result_ch (result_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  amp_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .data_mon    (data_if),
    .result_mon  (result_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Handshake flags registered at the rising edge and read at the falling edge.
  always @(posedge clk) begin
    byte_taken <= data_if.valid && data_if.ready;
    apb_done   <= psel && penable && pready;
  end

  // The receiver stalls at random.
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Run limit.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void put(input logic [7:0] b, input logic first, input logic last);
    stream_byte_t sb;
    sb.data  = b;
    sb.first = first;
    sb.last  = last;
    chunk_q.push_back(sb);
  endfunction

  // Appends the low n bytes of a word, most significant first.
  function automatic void put_bytes(input logic [31:0] word, input int n);
    for (int i = n - 1; i >= 0; i--) put(word[8*i +: 8], 1'b0, 1'b0);
  endfunction

  function automatic void put_header(input logic first, input logic [31:0] id,
                                     input logic [31:0] size, input logic [15:0] count);
    put(id[31:24], first, 1'b0);
    put_bytes(id, 3);
    put_bytes(size, 4);
    put_bytes({16'd0, count}, 2);
  endfunction

  // One marker entry: ID, position, Pascal name and the pad byte it needs.
  function automatic void put_entry(input logic [15:0] id, input logic [31:0] pos,
                                    input logic [7:0] len);
    put_bytes({16'd0, id}, 2);
    put_bytes(pos, 4);
    put(len, 1'b0, 1'b0);
    repeat (len) put(8'($urandom), 1'b0, 1'b0);
    if (!len[0]) put(8'($urandom), 1'b0, 1'b0);
  endfunction

  function automatic void trim(input int n);
    while (chunk_q.size() > n) void'(chunk_q.pop_back());
  endfunction

  function automatic void mark_last();
    stream_byte_t sb;
    sb = chunk_q.pop_back();
    sb.last = 1'b1;
    chunk_q.push_back(sb);
  endfunction

  function automatic logic [15:0] other_id();
    case ($urandom_range(4))
      0: return search_id ^ (16'd1 << $urandom_range(15));
      1: return {search_id[7:0], search_id[15:8]};
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] random_position();
    case ($urandom_range(5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] random_length();
    if ($urandom_range(15) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(6));
  endfunction

  // Mostly well-formed chunks with random content; the rest bad headers and noise.
  function automatic void queue_random_chunk();
    int          kind;
    int          n_entries;
    int          hit_at;
    logic [15:0] count;
    logic [31:0] word;
    kind = $urandom_range(99);
    if (kind < 72) begin
      case ($urandom_range(9))
        0: count = 16'd0;
        1: count = 16'hFFFF;
        2: count = 16'($urandom);
        default: count = 16'($urandom_range(1, 5));
      endcase
      n_entries = (count <= 5) ? int'(count) : $urandom_range(1, 4);
      // An index equal to the entry total means that no entry carries the target.
      hit_at = $urandom_range(0, n_entries);
      word = {1'b0, 31'($urandom)};
      if (word == 32'd0) word = 32'd1;
      put_header($urandom_range(9) != 0, amp_pkg::MARK_ID, word, count);
      for (int k = 0; k < n_entries; k++)
        put_entry((k == hit_at) ? search_id : other_id(), random_position(), random_length());
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 4)) put(8'($urandom), 1'b0, 1'b0);
      if ($urandom_range(6) == 0) begin
        trim($urandom_range(1, chunk_q.size()));
        mark_last();
      end else if ($urandom_range(1)) begin
        mark_last();
      end
    end else if (kind < 80) begin
      word = amp_pkg::MARK_ID;
      if ($urandom_range(1)) word = $urandom;
      else word[8*$urandom_range(3) +: 8] = 8'($urandom);
      put_header(1'b1, word, $urandom, 16'($urandom));
      trim($urandom_range(4, 10));
      if ($urandom_range(1)) mark_last();
    end else if (kind < 88) begin
      word = $urandom_range(1) ? 32'd0 : {1'b1, 31'($urandom)};
      put_header(1'b1, amp_pkg::MARK_ID, word, 16'($urandom));
      trim($urandom_range(8, 10));
      if ($urandom_range(1)) mark_last();
    end else begin
      repeat ($urandom_range(1, 12))
        put(8'($urandom), $urandom_range(3) == 0, $urandom_range(3) == 0);
    end
  endfunction

  // Offers one byte after a random idle stretch and holds it until the transfer.
  task automatic send_byte(input stream_byte_t sb);
    while ($urandom_range(99) < src_idle_pct) begin
      data_if.valid <= 1'b0;
      @(negedge clk);
    end
    data_if.valid      <= 1'b1;
    data_if.data_byte  <= sb.data;
    data_if.first_byte <= sb.first;
    data_if.last_byte  <= sb.last;
    do @(negedge clk); while (!byte_taken);
  endtask

  task automatic send_chunk();
    while (chunk_q.size() > 0) begin
      send_byte(chunk_q.pop_front());
      sent++;
    end
  endtask

  // Drains every pending result, then lets the parser go quiet.
  task automatic settle();
    data_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!apb_done);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_target(input logic [15:0] value);
    apb_access(1'b1, 3'd0, {16'($urandom), value});
    search_id = value;
    apb_access(1'b0, 3'd0, 32'd0);
  endtask

  // Main stimulus.
  initial begin
    logic [15:0] t;
    int          budget;
    rst                = 1'b1;
    data_if.valid      = 1'b0;
    data_if.data_byte  = '0;
    data_if.first_byte = 1'b0;
    data_if.last_byte  = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    src_idle_pct  = 10;
    sink_idle_pct = 48;

    // Right after reset, without a chunk start mark, against the reset target of zero.
    put_header(1'b0, amp_pkg::MARK_ID, 32'h0000_0020, 16'd1);
    put_entry(16'h0000, 32'h1234_5678, 8'd3);
    mark_last();
    send_chunk();
    settle();

    // A write to an unused address must leave the target alone.
    set_target(16'hFFFF);
    apb_access(1'b1, 3'd4, 32'h0000_5A5A);
    apb_access(1'b0, 3'd0, 32'd0);

    // Bad chunk ID, with the end mark on the byte that closes the chunk.
    put_header(1'b1, 32'h4D41_5258, 32'd8, 16'd1);
    trim(4);
    mark_last();
    send_chunk();

    // Zero and negative chunk sizes.
    put_header(1'b1, amp_pkg::MARK_ID, 32'd0, 16'd1);
    trim(8);
    send_chunk();
    put_header(1'b1, amp_pkg::MARK_ID, 32'h8000_0000, 16'd1);
    trim(8);
    send_chunk();

    // No markers at all.
    put_header(1'b1, amp_pkg::MARK_ID, 32'h7FFF_FFFF, 16'd0);
    send_chunk();

    // Match in the third entry, after an even and an odd name length.
    put_header(1'b1, amp_pkg::MARK_ID, 32'd40, 16'd3);
    put_entry(16'h00FF, 32'h0000_0000, 8'd0);
    put_entry(16'hFF00, 32'h0000_0001, 8'd1);
    put_entry(16'hFFFF, 32'hFFFF_FFFF, 8'd2);
    mark_last();
    send_chunk();

    // End mark on the last position byte of the match: the match wins.
    put_header(1'b1, amp_pkg::MARK_ID, 32'd1, 16'd1);
    put_entry(16'hFFFF, 32'hA5A5_0F0F, 8'd4);
    trim(16);
    mark_last();
    send_chunk();

    // No match closed by the final length byte, then a stray end mark that gives nothing.
    put_header(1'b1, amp_pkg::MARK_ID, 32'd30, 16'd2);
    put_entry(16'h0000, random_position(), 8'd1);
    put_entry(16'h1234, random_position(), 8'd5);
    trim(25);
    mark_last();
    put(8'h55, 1'b0, 1'b1);
    send_chunk();

    // Chunk ends inside a name.
    put_header(1'b1, amp_pkg::MARK_ID, 32'd30, 16'd2);
    put_entry(16'h0001, random_position(), 8'd4);
    trim(19);
    mark_last();
    send_chunk();

    // Restart in the middle of a header.
    put_header(1'b1, amp_pkg::MARK_ID, 32'h40, 16'd1);
    trim(5);
    put_header(1'b1, amp_pkg::MARK_ID, 32'd1, 16'd1);
    put_entry(16'hFFFF, 32'h0000_0000, 8'd0);
    send_chunk();

    // Chunk ends inside the size field.
    put_header(1'b1, amp_pkg::MARK_ID, 32'd5, 16'd1);
    trim(6);
    mark_last();
    send_chunk();

    // Largest count and the longest names; the chunk runs out first.
    put_header(1'b1, amp_pkg::MARK_ID, 32'h0000_0400, 16'hFFFF);
    put_entry(16'hABCD, random_position(), 8'd255);
    put_entry(16'h0001, random_position(), 8'd254);
    put_entry(16'h7FFF, random_position(), 8'd0);
    mark_last();
    send_chunk();

    // Random chunks under three idle patterns, each with several targets.
    for (int ph = 0; ph < 3; ph++) begin
      settle();
      src_idle_pct  = (ph == 0) ? 10 : (ph == 1) ? 48 : 0;
      sink_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 10 : 0;
      for (int seg = 0; seg < 3; seg++) begin
        settle();
        case (ph * 3 + seg)
          0: t = 16'h0000;
          1: t = 16'hFFFF;
          4: t = 16'h8000;
          5: t = 16'h0001;
          default: t = 16'($urandom);
        endcase
        set_target(t);
        budget = sent + 30;
        while (sent < budget) begin
          queue_random_chunk();
          send_chunk();
        end
      end
    end

    settle();
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
